### rtl/set_mode_finder_core_defines.svh
// ----------------------------------------------------------------------------
// Set mode finder - assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SET_MODE_FINDER_CORE_DEFINES_SVH
`define SET_MODE_FINDER_CORE_DEFINES_SVH

`ifndef SYNTH
// assertion with asynchronous active-low reset disable
`define SMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smf assertion failed");
// assertion without reset disable
`define SMF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("smf assertion failed");
`else
`define SMF_ASSERT(lbl, clk, rstn, prop)
`define SMF_ASSERT_NR(lbl, clk, prop)
`endif

`endif

### rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// Set mode finder - package
// Shared constants, controller state and command/status structs.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned VALUE_BITS_DEF = 8;

  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam int unsigned ERASE_W       = 9;
  localparam int unsigned ERASE_VAL_W   = 8;
  localparam int unsigned ERASE_NEG_BIT = 8;
  localparam logic [ERASE_W-1:0] ERASE_RST = 9'h1FF;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // item accepted this cycle
    logic scan_init;  // preset scan address and best candidate
    logic scan_rd;    // read one bin and step the scan address
    logic finish;     // result shown; clear histogram
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kept;       // at least one item counted in this set
    logic scan_end;   // scan address at the lowest bin
  } status_t;

endpackage

### rtl/smf_dpath.sv
// ----------------------------------------------------------------------------
// Set mode finder - datapath
// Histogram memory with read-modify-write forwarding, erase register and
// downward scan that keeps the first strictly larger count.
// ----------------------------------------------------------------------------
`include "set_mode_finder_core_defines.svh"

module smf_dpath #(
  parameter int unsigned VALUE_BITS = smf_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smf_pkg::ERASE_W-1:0]    cfg_data_i,
  input  logic [VALUE_BITS-1:0]          value_i,
  input  smf_pkg::cmd_t                  cmd_i,
  output smf_pkg::status_t               status_o,
  output logic [VALUE_BITS-1:0]          mode_value_o,
  output logic                           empty_set_o
);

  localparam int unsigned NumBins = 1 << VALUE_BITS;
  localparam int unsigned CmpW    = (VALUE_BITS > smf_pkg::ERASE_VAL_W) ?
                                    VALUE_BITS : smf_pkg::ERASE_VAL_W;
  localparam int unsigned CW      = smf_pkg::COUNT_W;

  logic [smf_pkg::ERASE_W-1:0] erase_q;

  logic [CW-1:0]         mem [NumBins];
  logic [CW-1:0]         mem_rd_q;
  logic                  vld_rd_q;
  logic [NumBins-1:0]    valid_q;

  logic                  rd_en;
  logic [VALUE_BITS-1:0] rd_addr;

  logic                  upd_vld_q;
  logic [VALUE_BITS-1:0] upd_addr_q;
  logic                  fwd_q;
  logic [CW-1:0]         fwd_data_q;

  logic [CW-1:0]         cur_cnt;
  logic [CW-1:0]         wr_data;
  logic                  erased;
  logic                  fwd_d;

  logic [VALUE_BITS-1:0] scan_addr_q;
  logic                  scan_vld_q;
  logic [VALUE_BITS-1:0] best_val_q;
  logic [CW-1:0]         best_cnt_q;
  logic                  kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= smf_pkg::ERASE_RST;
    end else if (cfg_we_i) begin
      erase_q <= cfg_data_i;
    end
  end

  // a negative erase value disables exclusion
  assign erased = !erase_q[smf_pkg::ERASE_NEG_BIT] &&
                  (CmpW'(value_i) == CmpW'(erase_q[smf_pkg::ERASE_VAL_W-1:0]));

  assign rd_en   = cmd_i.load | cmd_i.scan_rd;
  assign rd_addr = cmd_i.scan_rd ? scan_addr_q : value_i;

  // count seen by the update stage and by the scan compare
  assign cur_cnt = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rd_q : '0);
  assign wr_data = (cur_cnt == smf_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + CW'(1);

  // back-to-back hit on the bin being written: take the new count
  assign fwd_d = cmd_i.load && upd_vld_q && (upd_addr_q == value_i);

  always_ff @(posedge clk_i) begin
    if (upd_vld_q) begin
      mem[upd_addr_q] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      vld_rd_q   <= 1'b0;
      upd_vld_q  <= 1'b0;
      fwd_q      <= 1'b0;
      scan_vld_q <= 1'b0;
      kept_q     <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        valid_q <= '0;
      end else if (upd_vld_q) begin
        valid_q[upd_addr_q] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_q <= valid_q[rd_addr];
      end
      upd_vld_q  <= cmd_i.load && !erased;
      fwd_q      <= fwd_d;
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.finish) begin
        kept_q <= 1'b0;
      end else if (cmd_i.load && !erased) begin
        kept_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      upd_addr_q <= value_i;
    end
    if (fwd_d) begin
      fwd_data_q <= wr_data;
    end
    if (cmd_i.scan_init) begin
      scan_addr_q <= '1;
      best_val_q  <= '0;
      best_cnt_q  <= '0;
    end else begin
      if (cmd_i.scan_rd) begin
        scan_addr_q <= scan_addr_q - VALUE_BITS'(1);
      end
      // strict compare from the top down: ties keep the larger value
      if (scan_vld_q && (cur_cnt > best_cnt_q)) begin
        best_cnt_q <= cur_cnt;
        best_val_q <= scan_addr_q + VALUE_BITS'(1);
      end
    end
  end

  assign status_o.kept     = kept_q;
  assign status_o.scan_end = (scan_addr_q == '0);

  assign mode_value_o = best_val_q;
  assign empty_set_o  = !kept_q;

  `SMF_ASSERT(a_finish_clears_kept, clk_i, rst_ni, cmd_i.finish |=> !kept_q)
  `SMF_ASSERT(a_finish_clears_valid, clk_i, rst_ni, cmd_i.finish |=> (valid_q == '0))
  `SMF_ASSERT(a_no_fwd_in_scan, clk_i, rst_ni, scan_vld_q |-> !fwd_q)

endmodule

### rtl/smf_ctrl.sv
// ----------------------------------------------------------------------------
// Set mode finder - controller
// Sequences accumulation, write drain, bin scan and result strobe.
// ----------------------------------------------------------------------------
`include "set_mode_finder_core_defines.svh"

module smf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_item_i,
  input  smf_pkg::status_t status_i,
  output smf_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  smf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smf_pkg::ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      smf_pkg::ST_ACCUM: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
        if (start_i && last_item_i) begin
          state_d = smf_pkg::ST_DRAIN;
        end
      end
      smf_pkg::ST_DRAIN: begin
        // last bin write lands at the end of this cycle
        cmd_o.scan_init = 1'b1;
        state_d = status_i.kept ? smf_pkg::ST_SCAN : smf_pkg::ST_DONE;
      end
      smf_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_end) begin
          state_d = smf_pkg::ST_TAIL;
        end
      end
      smf_pkg::ST_TAIL: begin
        state_d = smf_pkg::ST_DONE;
      end
      smf_pkg::ST_DONE: begin
        done_o       = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = smf_pkg::ST_ACCUM;
      end
      default: begin
        state_d = smf_pkg::ST_ACCUM;
      end
    endcase
  end

  `SMF_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `SMF_ASSERT(a_last_goes_busy, clk_i, rst_ni,
              (start_i && !busy_o && last_item_i) |=> busy_o)
  `SMF_ASSERT(a_scan_holds, clk_i, rst_ni,
              (state_q == smf_pkg::ST_SCAN && !status_i.scan_end) |=>
              (state_q == smf_pkg::ST_SCAN))

endmodule

### rtl/set_mode_finder_core.sv
// After the last item of a set, drain, bin scan and tail states run before the result
//   strobes (drain only when every item was erased); the bin scan reads one histogram
//   entry a cycle. Throughput: one item per cycle within a set; busy in drain, scan,
//   tail and done after each last item (drain and done only if every item was erased).
// Results are shown on done_o for one cycle and cannot be stalled.
// Reset clears the histogram valid bits and sets the erase value to -1 (no exclusion).
// ----------------------------------------------------------------------------
// Set mode finder - top level
// Histogram-based mode of a byte set with an optional erased value.
// ----------------------------------------------------------------------------
module set_mode_finder_core #(
  parameter int unsigned VALUE_BITS = smf_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smf_pkg::ERASE_W-1:0] cfg_data_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [VALUE_BITS-1:0]       value_i,
  input  logic                        last_item_i,
  output logic                        done_o,
  output logic [VALUE_BITS-1:0]       mode_value_o,
  output logic                        empty_set_o
);

  smf_pkg::cmd_t    cmd;
  smf_pkg::status_t status;

  smf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_item_i (last_item_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  smf_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_value_o (mode_value_o),
    .empty_set_o  (empty_set_o)
  );

endmodule
